[hw/rtl/ranging_timing_budget_calc_core_assert.svh]
// ----------------------------------------------------------------------------
// Timing budget calculator assertion macros
// Shared assertion forms for the checker of the timing budget calculator.
// ----------------------------------------------------------------------------
`ifndef RANGING_TIMING_BUDGET_CALC_CORE_ASSERT_SVH
`define RANGING_TIMING_BUDGET_CALC_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTBC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rtbc: same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RTBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rtbc: next-cycle assertion failed");

`endif

[hw/rtl/rtbc_pkg.sv]
// ----------------------------------------------------------------------------
// Timing budget calculator package
// Shared widths, constants, status codes and sequencer types.
// ----------------------------------------------------------------------------
`default_nettype none

package rtbc_pkg;

   localparam int MP_W = 20;

   localparam logic [31:0] MACRO_SCALE = 32'(2304 * 1655);
   localparam logic [31:0] ROUND_HALF = 32'd500;
   localparam logic [MP_W-1:0] NS_PER_US = MP_W'(1000);

   localparam logic [31:0] START_OVERHEAD_US = 32'd1910;
   localparam logic [31:0] SET_START_OVERHEAD_US = 32'd1320;
   localparam logic [31:0] END_OVERHEAD_US = 32'd960;
   localparam logic [31:0] TCC_OVERHEAD_US = 32'd590;
   localparam logic [31:0] DSS_OVERHEAD_US = 32'd690;
   localparam logic [31:0] MSRC_OVERHEAD_US = 32'd660;
   localparam logic [31:0] PRE_OVERHEAD_US = 32'd660;
   localparam logic [31:0] FINAL_OVERHEAD_US = 32'd550;
   localparam logic [31:0] MIN_BUDGET_US = 32'd20000;
   localparam logic [31:0] MANTISSA_OVF_MASK = 32'hFFFF_FF00;

   localparam logic [6:0] VCSEL_CODE_MAX = 7'd126;
   localparam logic [7:0] EXP_LIMIT = 8'd16;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FINAL_OFF = 2'd1,
      STATUS_BELOW_MIN = 2'd2,
      STATUS_TOO_LARGE = 2'd3
   } rtbc_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_DIV_START,
      S_DIV_WAIT,
      S_SUM,
      S_TOTAL,
      S_CHECK,
      S_ENC_INIT,
      S_NORM,
      S_DONE
   } rtbc_state_type;

   typedef enum logic [2:0] {
      OP_MP_PRE,
      OP_MP_FIN,
      OP_MS_US,
      OP_PRE_US,
      OP_FIN_US,
      OP_MCLKS
   } rtbc_op_type;

   typedef enum logic [1:0] {
      TERM_TCC,
      TERM_STEP,
      TERM_PRE
   } rtbc_term_type;

endpackage

`default_nettype wire

[hw/rtl/rtbc_mul.sv]
// ----------------------------------------------------------------------------
// Timing budget calculator multiplier
// Registered 32 by 20 bit multiplier keeping the low 32 bits of the product.
// ----------------------------------------------------------------------------
`default_nettype none

module rtbc_mul (
   input  logic                       clock,
   input  logic [31:0]                mul_a,
   input  logic [rtbc_pkg::MP_W-1:0]  mul_b,
   output logic [31:0]                mul_prod
);

   localparam int FULL_W = 32 + rtbc_pkg::MP_W;

   logic [FULL_W-1:0] full_prod;
   logic [31:0]       prod_ff;

   assign full_prod = FULL_W'(mul_a) * FULL_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= full_prod[31:0];
   end

   assign mul_prod = prod_ff;

endmodule

`default_nettype wire

[hw/rtl/rtbc_div.sv]
// ----------------------------------------------------------------------------
// Timing budget calculator divider
// Restoring divider, one quotient bit per cycle, 32-bit dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module rtbc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       div_start,
   input  logic [31:0]                div_dividend,
   input  logic [rtbc_pkg::MP_W-1:0]  div_divisor,
   output logic                       div_done,
   output logic [31:0]                div_quotient
);

   localparam int MP_W = rtbc_pkg::MP_W;

   logic            busy_ff;
   logic            busy_in;
   logic            done_ff;
   logic            done_in;
   logic [4:0]      cnt_ff;
   logic [4:0]      cnt_in;
   logic [31:0]     quo_ff;
   logic [MP_W-1:0] rem_ff;
   logic [MP_W:0]   rem_shift;
   logic            rem_ge;
   logic [MP_W:0]   rem_sub;

   assign rem_shift = {rem_ff, quo_ff[31]};
   assign rem_ge = rem_shift >= {1'b0, div_divisor};
   assign rem_sub = rem_shift - {1'b0, div_divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      if (div_start) begin
         busy_in = 1'b1;
         cnt_in = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         quo_ff <= div_dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[30:0], rem_ge};
         rem_ff <= rem_ge ? rem_sub[MP_W-1:0] : rem_shift[MP_W-1:0];
      end
   end

   assign div_done = done_ff;
   assign div_quotient = quo_ff;

endmodule

`default_nettype wire

[hw/rtl/ranging_timing_budget_calc_core.sv]
// ----------------------------------------------------------------------------
// Ranging timing budget calculator
// Computes the present measurement budget and a new final-range timeout code
// with a small sequencer around one shared multiplier and one serial divider.
//
//   Channel  Direction  Handshake            Content
//   req_     in         req_valid/req_stall  enables, VCSEL codes, timeouts,
//                                            requested budget
//   rsp_     out        rsp_valid/rsp_stall  current budget, status, code
//
// From accept to accept an item makes five multiply-divide passes through the
// 32-step divider, then sums its terms, forms the totals and runs the checks.
// A new code adds a sixth pass and then the normalisation of the new code.
// The input is stalled while an item is in progress; a stalled result holds the
// sequencer, while an idle block takes the next item as the last result waits.
// Reset is synchronous and clears the sequencer and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module ranging_timing_budget_calc_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_sequence_enables,
   input  logic [6:0]  req_pre_vcsel_code,
   input  logic [6:0]  req_final_vcsel_code,
   input  logic [7:0]  req_msrc_timeout_code,
   input  logic [15:0] req_pre_timeout_code,
   input  logic [15:0] req_final_timeout_code,
   input  logic [31:0] req_requested_budget_us,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_current_budget_us,
   output logic [1:0]  rsp_set_status,
   output logic [15:0] rsp_new_final_code
);

   localparam int MP_W = rtbc_pkg::MP_W;
   localparam int EN_MSRC = 2;
   localparam int EN_DSS = 3;
   localparam int EN_TCC = 4;
   localparam int EN_PRE = 6;
   localparam int EN_FINAL = 7;

   function automatic logic [7:0] vcsel_period(input logic [6:0] code);
      logic [6:0] c;
      c = (code > rtbc_pkg::VCSEL_CODE_MAX) ? rtbc_pkg::VCSEL_CODE_MAX : code;
      return {c + 7'd1, 1'b0};
   endfunction

   function automatic logic [15:0] decode_mclks(input logic [15:0] code);
      logic [15:0] shifted;
      shifted = 16'(code[7:0]) << code[11:8];
      if (code[15:8] >= rtbc_pkg::EXP_LIMIT) begin
         shifted = '0;
      end
      return shifted + 16'd1;
   endfunction

   rtbc_pkg::rtbc_state_type  state_ff;
   rtbc_pkg::rtbc_state_type  state_in;
   rtbc_pkg::rtbc_op_type     op_ff;
   rtbc_pkg::rtbc_term_type   term_ff;
   rtbc_pkg::rtbc_status_type status_ff;
   rtbc_pkg::rtbc_status_type status_in;
   rtbc_pkg::rtbc_status_type out_status_ff;

   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            accept;
   logic            out_load;
   logic            div_start;
   logic            div_done;
   logic [31:0]     div_quotient;
   logic [31:0]     div_dividend;
   logic [MP_W-1:0] div_divisor;
   logic [31:0]     mul_a;
   logic [MP_W-1:0] mul_b;
   logic [31:0]     mul_prod;
   logic [31:0]     addend;
   logic [31:0]     term_value;
   logic [31:0]     fin_term;
   logic [15:0]     pre_mclks_dec;
   logic [15:0]     fin_mclks_dec;

   logic            tcc_ff;
   logic            dss_ff;
   logic            msrc_ff;
   logic            pre_ff;
   logic            fin_ff;
   logic [7:0]      pre_p_ff;
   logic [7:0]      fin_p_ff;
   logic [8:0]      ms_mclks_ff;
   logic [15:0]     pre_mclks_ff;
   logic [15:0]     fin_mclks_ff;
   logic [31:0]     req_ff;
   logic [MP_W-1:0] mp_pre_ff;
   logic [MP_W-1:0] mp_fin_ff;
   logic [31:0]     ms_us_ff;
   logic [31:0]     pre_us_ff;
   logic [31:0]     fin_us_ff;
   logic [31:0]     acc_ff;
   logic [31:0]     cur_ff;
   logic [31:0]     used_ff;
   logic [31:0]     lsb_ff;
   logic [4:0]      msb_ff;
   logic [15:0]     code_ff;
   logic [31:0]     out_budget_ff;
   logic [15:0]     out_code_ff;

   rtbc_mul u_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_prod (mul_prod)
   );

   rtbc_div u_div (
      .clock        (clock),
      .reset        (reset),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      addend = rtbc_pkg::ROUND_HALF;
      div_divisor = rtbc_pkg::NS_PER_US;
      case (op_ff)
         rtbc_pkg::OP_MP_PRE: begin
            mul_a = rtbc_pkg::MACRO_SCALE;
            mul_b = MP_W'(pre_p_ff);
         end
         rtbc_pkg::OP_MP_FIN: begin
            mul_a = rtbc_pkg::MACRO_SCALE;
            mul_b = MP_W'(fin_p_ff);
         end
         rtbc_pkg::OP_MS_US: begin
            mul_a = 32'(ms_mclks_ff);
            mul_b = mp_pre_ff;
         end
         rtbc_pkg::OP_PRE_US: begin
            mul_a = 32'(pre_mclks_ff);
            mul_b = mp_pre_ff;
         end
         rtbc_pkg::OP_FIN_US: begin
            mul_a = 32'(fin_mclks_ff);
            mul_b = mp_fin_ff;
         end
         rtbc_pkg::OP_MCLKS: begin
            mul_a = used_ff;
            mul_b = rtbc_pkg::NS_PER_US;
            addend = 32'(mp_fin_ff[MP_W-1:1]);
            div_divisor = mp_fin_ff;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   assign div_dividend = mul_prod + addend;

   always_comb begin
      case (term_ff)
         rtbc_pkg::TERM_TCC: begin
            term_value = tcc_ff ? ms_us_ff + rtbc_pkg::TCC_OVERHEAD_US : '0;
         end
         rtbc_pkg::TERM_STEP: begin
            if (dss_ff) begin
               term_value = {ms_us_ff[30:0], 1'b0} + {rtbc_pkg::DSS_OVERHEAD_US[30:0], 1'b0};
            end else if (msrc_ff) begin
               term_value = ms_us_ff + rtbc_pkg::MSRC_OVERHEAD_US;
            end else begin
               term_value = '0;
            end
         end
         rtbc_pkg::TERM_PRE: begin
            term_value = pre_ff ? pre_us_ff + rtbc_pkg::PRE_OVERHEAD_US : '0;
         end
         default: begin
            term_value = '0;
         end
      endcase
   end

   assign fin_term = fin_ff ? fin_us_ff + rtbc_pkg::FINAL_OVERHEAD_US : '0;
   assign pre_mclks_dec = decode_mclks(req_pre_timeout_code);
   assign fin_mclks_dec = decode_mclks(req_final_timeout_code);

   always_comb begin
      if (req_ff < rtbc_pkg::MIN_BUDGET_US) begin
         status_in = rtbc_pkg::STATUS_BELOW_MIN;
      end else if (!fin_ff) begin
         status_in = rtbc_pkg::STATUS_FINAL_OFF;
      end else if (used_ff > req_ff) begin
         status_in = rtbc_pkg::STATUS_TOO_LARGE;
      end else begin
         status_in = rtbc_pkg::STATUS_OK;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rtbc_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = rtbc_pkg::S_MUL;
            end
         end
         rtbc_pkg::S_MUL: begin
            state_in = rtbc_pkg::S_DIV_START;
         end
         rtbc_pkg::S_DIV_START: begin
            state_in = rtbc_pkg::S_DIV_WAIT;
         end
         rtbc_pkg::S_DIV_WAIT: begin
            if (div_done) begin
               if (op_ff == rtbc_pkg::OP_FIN_US) begin
                  state_in = rtbc_pkg::S_SUM;
               end else if (op_ff == rtbc_pkg::OP_MCLKS) begin
                  state_in = rtbc_pkg::S_ENC_INIT;
               end else begin
                  state_in = rtbc_pkg::S_MUL;
               end
            end
         end
         rtbc_pkg::S_SUM: begin
            if (term_ff == rtbc_pkg::TERM_PRE) begin
               state_in = rtbc_pkg::S_TOTAL;
            end
         end
         rtbc_pkg::S_TOTAL: begin
            state_in = rtbc_pkg::S_CHECK;
         end
         rtbc_pkg::S_CHECK: begin
            state_in = (status_in == rtbc_pkg::STATUS_OK) ? rtbc_pkg::S_MUL
                                                          : rtbc_pkg::S_DONE;
         end
         rtbc_pkg::S_ENC_INIT: begin
            state_in = (lsb_ff == '0) ? rtbc_pkg::S_DONE : rtbc_pkg::S_NORM;
         end
         rtbc_pkg::S_NORM: begin
            if ((lsb_ff & rtbc_pkg::MANTISSA_OVF_MASK) == '0) begin
               state_in = rtbc_pkg::S_DONE;
            end
         end
         rtbc_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = rtbc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rtbc_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = state_ff != rtbc_pkg::S_IDLE;
      div_start = state_ff == rtbc_pkg::S_DIV_START;
      out_load = (state_ff == rtbc_pkg::S_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   assign accept = req_valid && !req_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtbc_pkg::S_IDLE;
         op_ff <= rtbc_pkg::OP_MP_PRE;
         term_ff <= rtbc_pkg::TERM_TCC;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            op_ff <= rtbc_pkg::OP_MP_PRE;
            term_ff <= rtbc_pkg::TERM_TCC;
         end else if (state_ff == rtbc_pkg::S_DIV_WAIT && div_done
                      && op_ff != rtbc_pkg::OP_FIN_US && op_ff != rtbc_pkg::OP_MCLKS) begin
            op_ff <= rtbc_pkg::rtbc_op_type'(op_ff + 3'd1);
         end else if (state_ff == rtbc_pkg::S_SUM && term_ff != rtbc_pkg::TERM_PRE) begin
            term_ff <= rtbc_pkg::rtbc_term_type'(term_ff + 2'd1);
         end else if (state_ff == rtbc_pkg::S_CHECK) begin
            op_ff <= rtbc_pkg::OP_MCLKS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tcc_ff <= req_sequence_enables[EN_TCC];
         dss_ff <= req_sequence_enables[EN_DSS];
         msrc_ff <= req_sequence_enables[EN_MSRC];
         pre_ff <= req_sequence_enables[EN_PRE];
         fin_ff <= req_sequence_enables[EN_FINAL];
         pre_p_ff <= vcsel_period(req_pre_vcsel_code);
         fin_p_ff <= vcsel_period(req_final_vcsel_code);
         ms_mclks_ff <= 9'(req_msrc_timeout_code) + 9'd1;
         pre_mclks_ff <= pre_mclks_dec;
         fin_mclks_ff <= req_sequence_enables[EN_PRE] ? fin_mclks_dec - pre_mclks_dec
                                                      : fin_mclks_dec;
         req_ff <= req_requested_budget_us;
         acc_ff <= '0;
         code_ff <= '0;
      end
      if (state_ff == rtbc_pkg::S_DIV_WAIT && div_done) begin
         case (op_ff)
            rtbc_pkg::OP_MP_PRE: mp_pre_ff <= div_quotient[MP_W-1:0];
            rtbc_pkg::OP_MP_FIN: mp_fin_ff <= div_quotient[MP_W-1:0];
            rtbc_pkg::OP_MS_US:  ms_us_ff <= div_quotient;
            rtbc_pkg::OP_PRE_US: pre_us_ff <= div_quotient;
            rtbc_pkg::OP_FIN_US: fin_us_ff <= div_quotient;
            rtbc_pkg::OP_MCLKS: begin
               lsb_ff <= div_quotient + (pre_ff ? 32'(pre_mclks_ff) : 32'd0);
            end
            default: begin
               lsb_ff <= lsb_ff;
            end
         endcase
      end
      if (state_ff == rtbc_pkg::S_SUM) begin
         acc_ff <= acc_ff + term_value;
      end
      if (state_ff == rtbc_pkg::S_TOTAL) begin
         cur_ff <= acc_ff + rtbc_pkg::START_OVERHEAD_US + rtbc_pkg::END_OVERHEAD_US
                   + fin_term;
         used_ff <= acc_ff + rtbc_pkg::SET_START_OVERHEAD_US + rtbc_pkg::END_OVERHEAD_US
                    + rtbc_pkg::FINAL_OVERHEAD_US;
      end
      if (state_ff == rtbc_pkg::S_CHECK) begin
         status_ff <= status_in;
         used_ff <= req_ff - used_ff;
      end
      if (state_ff == rtbc_pkg::S_ENC_INIT) begin
         lsb_ff <= lsb_ff - 32'd1;
         msb_ff <= '0;
      end
      if (state_ff == rtbc_pkg::S_NORM) begin
         if ((lsb_ff & rtbc_pkg::MANTISSA_OVF_MASK) != '0) begin
            lsb_ff <= {1'b0, lsb_ff[31:1]};
            msb_ff <= msb_ff + 5'd1;
         end else begin
            code_ff <= {3'b000, msb_ff, lsb_ff[7:0]};
         end
      end
      if (out_load) begin
         out_budget_ff <= cur_ff;
         out_status_ff <= status_ff;
         out_code_ff <= code_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_current_budget_us = out_budget_ff;
   assign rsp_set_status = out_status_ff;
   assign rsp_new_final_code = out_code_ff;

endmodule

`default_nettype wire

[hw/rtl/rtbc_checker.sv]
// ----------------------------------------------------------------------------
// Timing budget calculator checker
// Port-level assertions on the calculator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ranging_timing_budget_calc_core_assert.svh"

module rtbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_set_status,
   input logic [15:0] rsp_new_final_code
);

   logic rsp_wait;
   logic rsp_not_ok;

   assign rsp_wait = rsp_valid && rsp_stall;
   assign rsp_not_ok = rsp_valid && (rsp_set_status != rtbc_pkg::STATUS_OK);

   // A result with any status other than success carries a zero code.
   `RTBC_ASSERT_SAME(a_code_zero, clock, reset, rsp_not_ok, rsp_new_final_code == 16'd0)

   // Once an item is taken the block is busy in the following cycle.
   `RTBC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   `RTBC_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_wait, rsp_valid)

   `RTBC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_wait, $stable(rsp_new_final_code))

endmodule

bind ranging_timing_budget_calc_core rtbc_checker u_rtbc_checker (.*);

`default_nettype wire

[sim/tb_ranging_timing_budget_calc_core.sv]
// ----------------------------------------------------------------------------
// Testbench for the ranging timing budget calculator
// Sends directed and random snapshots of the sensor's sequence and timeout
// settings, predicts the current budget, the set status and the new
// final-range code for each item, and checks every result in order. The
// sender and the receiver idle at random in changing proportions.
// ----------------------------------------------------------------------------
module tb_ranging_timing_budget_calc_core;

   localparam logic [31:0] START_US      = 32'd1910;
   localparam logic [31:0] SET_START_US  = 32'd1320;
   localparam logic [31:0] END_US        = 32'd960;
   localparam logic [31:0] TCC_US        = 32'd590;
   localparam logic [31:0] DSS_US        = 32'd690;
   localparam logic [31:0] MSRC_US       = 32'd660;
   localparam logic [31:0] PRE_US        = 32'd660;
   localparam logic [31:0] FINAL_US      = 32'd550;
   localparam logic [31:0] MIN_US        = 32'd20000;
   localparam int          TAIL_CYCLES   = 300;

   typedef struct {
      logic [7:0]  enables;
      logic [6:0]  pre_vcsel;
      logic [6:0]  final_vcsel;
      logic [7:0]  msrc_timeout;
      logic [15:0] pre_timeout;
      logic [15:0] final_timeout;
      logic [31:0] want_us;
   } budget_req_type;

   typedef struct {
      logic [31:0]               current_budget;
      rtbc_pkg::rtbc_status_type status;
      logic [15:0]               final_code;
   } budget_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_sequence_enables = '0;
   logic [6:0]  req_pre_vcsel_code = '0;
   logic [6:0]  req_final_vcsel_code = '0;
   logic [7:0]  req_msrc_timeout_code = '0;
   logic [15:0] req_pre_timeout_code = '0;
   logic [15:0] req_final_timeout_code = '0;
   logic [31:0] req_requested_budget_us = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_current_budget_us;
   logic [1:0]  rsp_set_status;
   logic [15:0] rsp_new_final_code;

   budget_rsp_type pending_budgets[$];
   budget_rsp_type head_budget;
   int             req_idle_pct = 10;
   int             rsp_idle_pct = 52;
   int             items_sent = 0;
   int             results_checked = 0;
   int             error_count = 0;
   int             status_seen[4] = '{0, 0, 0, 0};

   ranging_timing_budget_calc_core uut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_sequence_enables    (req_sequence_enables),
      .req_pre_vcsel_code      (req_pre_vcsel_code),
      .req_final_vcsel_code    (req_final_vcsel_code),
      .req_msrc_timeout_code   (req_msrc_timeout_code),
      .req_pre_timeout_code    (req_pre_timeout_code),
      .req_final_timeout_code  (req_final_timeout_code),
      .req_requested_budget_us (req_requested_budget_us),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_current_budget_us   (rsp_current_budget_us),
      .rsp_set_status          (rsp_set_status),
      .rsp_new_final_code      (rsp_new_final_code)
   );

   always #10 clock = ~clock;

   // Prediction of the block, all sums wrapping at 32 bits.

   function automatic logic [31:0] vcsel_pclks(logic [6:0] code);
      logic [31:0] c;
      c = (code > 7'd126) ? 32'd126 : 32'(code);
      return (c + 32'd1) * 32'd2;
   endfunction

   function automatic logic [31:0] macro_clock_ns(logic [31:0] pclks);
      return (32'd2304 * pclks * 32'd1655 + 32'd500) / 32'd1000;
   endfunction

   function automatic logic [31:0] mclks_as_us(logic [31:0] mclks, logic [31:0] pclks);
      return (mclks * macro_clock_ns(pclks) + 32'd500) / 32'd1000;
   endfunction

   function automatic logic [31:0] timeout_to_mclks(logic [15:0] code);
      logic [31:0] v;
      v = (code[15:8] >= 8'd16) ? 32'd0 : ((32'(code[7:0]) << code[15:8]) & 32'hFFFF);
      return (v + 32'd1) & 32'hFFFF;
   endfunction

   function automatic budget_rsp_type predict_budget(budget_req_type r);
      budget_rsp_type p;
      logic [31:0] pre_p, fin_p, ms_us, pre_mclks, pre_us, fin_mclks, fin_us;
      logic [31:0] common, used, mp, m, lsb, msb;
      pre_p = vcsel_pclks(r.pre_vcsel);
      fin_p = vcsel_pclks(r.final_vcsel);
      ms_us = mclks_as_us(32'(r.msrc_timeout) + 32'd1, pre_p);
      pre_mclks = timeout_to_mclks(r.pre_timeout);
      pre_us = mclks_as_us(pre_mclks, pre_p);
      fin_mclks = timeout_to_mclks(r.final_timeout);
      if (r.enables[6]) begin
         fin_mclks = (fin_mclks - pre_mclks) & 32'hFFFF;
      end
      fin_us = mclks_as_us(fin_mclks, fin_p);
      common = 32'd0;
      if (r.enables[4]) begin
         common += ms_us + TCC_US;
      end
      if (r.enables[3]) begin
         common += 32'd2 * (ms_us + DSS_US);
      end else if (r.enables[2]) begin
         common += ms_us + MSRC_US;
      end
      if (r.enables[6]) begin
         common += pre_us + PRE_US;
      end
      p.current_budget = START_US + END_US + common;
      if (r.enables[7]) begin
         p.current_budget += fin_us + FINAL_US;
      end
      p.final_code = 16'd0;
      used = SET_START_US + END_US + common + FINAL_US;
      if (r.want_us < MIN_US) begin
         p.status = rtbc_pkg::STATUS_BELOW_MIN;
      end else if (!r.enables[7]) begin
         p.status = rtbc_pkg::STATUS_FINAL_OFF;
      end else if (used > r.want_us) begin
         p.status = rtbc_pkg::STATUS_TOO_LARGE;
      end else begin
         p.status = rtbc_pkg::STATUS_OK;
         mp = macro_clock_ns(fin_p);
         m = ((r.want_us - used) * 32'd1000 + mp / 32'd2) / mp;
         if (r.enables[6]) begin
            m += pre_mclks;
         end
         if (m != 32'd0) begin
            lsb = m - 32'd1;
            msb = 32'd0;
            while ((lsb & 32'hFFFF_FF00) != 32'd0) begin
               lsb = lsb >> 1;
               msb++;
            end
            p.final_code = {msb[7:0], lsb[7:0]};
         end
      end
      return p;
   endfunction

   // Sender: called at a falling edge, returns at the falling edge after the
   // item was taken. Valid stays high when the next item follows directly.
   task automatic send_item(budget_req_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_sequence_enables    = r.enables;
      req_pre_vcsel_code      = r.pre_vcsel;
      req_final_vcsel_code    = r.final_vcsel;
      req_msrc_timeout_code   = r.msrc_timeout;
      req_pre_timeout_code    = r.pre_timeout;
      req_final_timeout_code  = r.final_timeout;
      req_requested_budget_us = r.want_us;
      req_valid = 1'b1;
      do begin
         @(posedge clock);
      end while (req_stall);
      pending_budgets.push_back(predict_budget(r));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_budgets.size() != 0) begin
         @(negedge clock);
      end
   endtask

   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_budgets.size() == 0) begin
            $error("unexpected result: current_budget_us %0d", rsp_current_budget_us);
            error_count++;
         end else begin
            head_budget = pending_budgets.pop_front();
            results_checked++;
            status_seen[head_budget.status]++;
            if (rsp_current_budget_us !== head_budget.current_budget) begin
               $error("current_budget_us: expected %0d, actual %0d",
                      head_budget.current_budget, rsp_current_budget_us);
               error_count++;
            end
            if (rsp_set_status !== head_budget.status) begin
               $error("set_status: expected %0d, actual %0d",
                      head_budget.status, rsp_set_status);
               error_count++;
            end
            if (rsp_new_final_code !== head_budget.final_code) begin
               $error("new_final_code: expected 0x%04h, actual 0x%04h",
                      head_budget.final_code, rsp_new_final_code);
               error_count++;
            end
         end
      end
   end

   task automatic test_field_extremes();
      send_item(budget_req_type'{8'h00, 7'd0, 7'd0, 8'h00, 16'h0000, 16'h0000, 32'd0});
      send_item(budget_req_type'{8'hFF, 7'd126, 7'd126, 8'hFF, 16'hFFFF, 16'hFFFF,
                                 32'hFFFF_FFFF});
      send_item(budget_req_type'{8'h2A, 7'h55, 7'h2A, 8'h55, 16'h0A55, 16'h05AA,
                                 32'hAAAA_5555});
      send_item(budget_req_type'{8'hD5, 7'h2A, 7'h55, 8'hAA, 16'h05AA, 16'h0A55,
                                 32'h5555_AAAA});
   endtask

   task automatic test_step_enables();
      logic [7:0] step_sets[8];
      step_sets = '{8'h80, 8'h90, 8'h88, 8'h84, 8'hC0, 8'h8C, 8'hDC, 8'hA3};
      foreach (step_sets[i]) begin
         send_item(budget_req_type'{step_sets[i], 7'd7, 7'd5, 8'h20, 16'h0205, 16'h0310,
                                    32'd33000});
      end
   endtask

   task automatic test_special_cases();
      // VCSEL code 127 is saturated to 126.
      send_item(budget_req_type'{8'hDC, 7'd127, 7'd127, 8'h10, 16'h0103, 16'h0204,
                                 32'd900000});
      // Exponents of 16 and above decode to a count of one.
      send_item(budget_req_type'{8'hC0, 7'd3, 7'd4, 8'h01, 16'h10FF, 16'h10FF,
                                 32'd60000});
      send_item(budget_req_type'{8'h80, 7'd3, 7'd4, 8'h01, 16'hFF01, 16'hFF01,
                                 32'd60000});
      // The decoded count is cut to 16 bits.
      send_item(budget_req_type'{8'hC0, 7'd2, 7'd2, 8'h00, 16'h08FF, 16'h0FFF,
                                 32'hFFFF_FFFF});
      // A final count below the pre-range count wraps.
      send_item(budget_req_type'{8'hC0, 7'd6, 7'd4, 8'h08, 16'h0AFF, 16'h0001,
                                 32'd500000});
      // The minimum test comes before the final-step test.
      send_item(budget_req_type'{8'h5C, 7'd6, 7'd4, 8'h08, 16'h0102, 16'h0203,
                                 32'd19999});
      send_item(budget_req_type'{8'h80, 7'd6, 7'd4, 8'h08, 16'h0102, 16'h0203,
                                 32'd19999});
      send_item(budget_req_type'{8'h80, 7'd6, 7'd4, 8'h08, 16'h0102, 16'h0203,
                                 32'd20000});
      send_item(budget_req_type'{8'h40, 7'd6, 7'd4, 8'h08, 16'h0102, 16'h0203,
                                 32'd20000});
      // Overhead larger than the request.
      send_item(budget_req_type'{8'hDC, 7'd126, 7'd126, 8'hFF, 16'h0FFF, 16'h0100,
                                 32'd20000});
      // The spare time wraps to zero macro clocks, which encodes as code 0.
      send_item(budget_req_type'{8'h80, 7'd0, 7'd0, 8'h00, 16'h0000, 16'h0000,
                                 32'd4297798});
   endtask

   task automatic send_random_item();
      budget_req_type r;
      if ($urandom_range(99) < 75) begin
         r.enables = 8'($urandom);
         if ($urandom_range(99) < 85) begin
            r.enables[7] = 1'b1;
         end
         r.pre_vcsel     = ($urandom_range(99) < 70) ? 7'($urandom_range(20))
                                                     : 7'($urandom_range(126));
         r.final_vcsel   = ($urandom_range(99) < 70) ? 7'($urandom_range(20))
                                                     : 7'($urandom_range(126));
         r.msrc_timeout  = 8'($urandom);
         r.pre_timeout   = {8'($urandom_range(15)), 8'($urandom)};
         r.final_timeout = {8'($urandom_range(15)), 8'($urandom)};
         r.want_us       = ($urandom_range(99) < 80) ? $urandom_range(1000000, 20000)
                                                     : $urandom_range(40000, 0);
      end else begin
         r.enables       = 8'($urandom);
         r.pre_vcsel     = 7'($urandom_range(126));
         r.final_vcsel   = 7'($urandom_range(126));
         r.msrc_timeout  = 8'($urandom);
         r.pre_timeout   = 16'($urandom);
         r.final_timeout = 16'($urandom);
         r.want_us       = $urandom;
      end
      send_item(r);
   endtask

   task automatic test_random_traffic(int count, int req_pct, int rsp_pct);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      repeat (count) begin
         send_random_item();
      end
   endtask

   task automatic test_restart_after_drain();
      repeat (5) begin
         send_random_item();
      end
      wait_drained();
      repeat (5) begin
         send_random_item();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_field_extremes();
      test_step_enables();
      test_special_cases();
      test_random_traffic(300, 10, 52);
      test_restart_after_drain();
      test_random_traffic(300, 52, 10);
      test_random_traffic(300, 0, 0);
      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (pending_budgets.size() != 0) begin
         $error("%0d expected results never arrived", pending_budgets.size());
         error_count++;
      end
      $display("Run covered %0d items and %0d results, directed extremes and random traffic.",
               items_sent, results_checked);
      $display("Status counts: ok %0d, final off %0d, below minimum %0d, too large %0d.",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #30000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
